/* design/jwwlb_pkg.sv */
`default_nettype none
package jwwlb_pkg;

  localparam int CODE_W  = 8;
  localparam int WRAP_W  = 12;
  localparam int PEN_W   = 13;
  localparam int SPC_W   = 12;
  localparam int CNT_W   = 16;
  localparam int FRAC_W  = 8;
  localparam int Q8_W    = 20;
  localparam int KIND_W  = 2;

  localparam int DIV_NUM_W = WRAP_W + FRAC_W;
  localparam int DIV_DEN_W = SPC_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [CODE_W-1:0] CODE_LF    = 8'h0a;
  localparam logic [CODE_W-1:0] CODE_SPACE = 8'h20;

  localparam logic [KIND_W-1:0] KIND_LF     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRAP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FORCED = 2'd2;

  localparam logic REG_WRAP_WIDTH    = 1'b0;
  localparam logic REG_SPACE_ADVANCE = 1'b1;

  localparam logic [WRAP_W-1:0] WRAP_WIDTH_RST = 12'd450;
  localparam int                SPACE_ADV_RST  = 6;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic need_div;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* design/jwwlb_div.sv */
`default_nettype none
module jwwlb_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [jwwlb_pkg::DIV_NUM_W-1:0]    numer,
  input  wire logic [jwwlb_pkg::DIV_DEN_W-1:0]    denom,
  output logic                                    busy,
  output logic      [jwwlb_pkg::DIV_NUM_W-1:0]    quot
);

  logic                               busy_r;
  logic [jwwlb_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [jwwlb_pkg::DIV_NUM_W-1:0]    num_r;
  logic [jwwlb_pkg::DIV_DEN_W-1:0]    den_r;
  logic [jwwlb_pkg::DIV_DEN_W-1:0]    rem_r;
  logic [jwwlb_pkg::DIV_DEN_W:0]      trial;
  logic                               qbit;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, num_r[jwwlb_pkg::DIV_NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= jwwlb_pkg::DIV_CNT_W'(jwwlb_pkg::DIV_NUM_W);
    end else if (busy_r) begin
      busy_r <= (cnt_r != jwwlb_pkg::DIV_CNT_W'(1));
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      den_r <= denom;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[jwwlb_pkg::DIV_NUM_W-2:0], qbit};
      rem_r <= qbit ? jwwlb_pkg::DIV_DEN_W'(trial - {1'b0, den_r})
                    : trial[jwwlb_pkg::DIV_DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = num_r;

endmodule
`default_nettype wire

/* design/jwwlb_dp.sv */
`default_nettype none
module jwwlb_dp #(
  parameter int POSITION_BITS = 24,
  parameter int ADVANCE_BITS  = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire jwwlb_pkg::cmd_t                   cmd,
  output jwwlb_pkg::sts_t                        sts,
  input  wire logic [jwwlb_pkg::CODE_W-1:0]      in_char_code,
  input  wire logic [ADVANCE_BITS-1:0]           in_glyph_advance,
  input  wire logic [jwwlb_pkg::WRAP_W-1:0]      wrap_width,
  input  wire logic [ADVANCE_BITS-1:0]           space_advance,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [POSITION_BITS-1:0]               out_line_start,
  output logic [jwwlb_pkg::CNT_W-1:0]            out_line_length,
  output logic [jwwlb_pkg::CNT_W-1:0]            out_glyph_count,
  output logic [jwwlb_pkg::Q8_W-1:0]             out_space_width_q8,
  output logic [jwwlb_pkg::KIND_W-1:0]           out_break_kind,
  output logic [POSITION_BITS-1:0]               out_line_index
);

  localparam int PW = jwwlb_pkg::PEN_W;
  localparam int CW = jwwlb_pkg::CNT_W;
  localparam int SW = jwwlb_pkg::SPC_W;
  localparam int QW = jwwlb_pkg::Q8_W;

  logic [jwwlb_pkg::CODE_W-1:0] char_r;
  logic [ADVANCE_BITS-1:0]      adv_r;

  logic [POSITION_BITS-1:0] char_pos_r,  char_pos_nxt;
  logic [POSITION_BITS-1:0] line_begin_r, line_begin_nxt;
  logic [CW-1:0]            line_chars_r, line_chars_nxt;
  logic [CW-1:0]            line_glyphs_r, line_glyphs_nxt;
  logic [PW-1:0]            pen_r, pen_nxt;
  logic [SW-1:0]            spc_r, spc_nxt;
  logic [PW-1:0]            pal_r, pal_nxt;
  logic [CW-1:0]            cals_r, cals_nxt;
  logic [CW-1:0]            gals_r, gals_nxt;
  logic [POSITION_BITS-1:0] lines_r;

  logic                     out_valid_r;
  logic [POSITION_BITS-1:0] o_start_r;
  logic [CW-1:0]            o_len_r, o_glyphs_r;
  logic [QW-1:0]            o_width_r;
  logic [jwwlb_pkg::KIND_W-1:0] o_kind_r;
  logic [POSITION_BITS-1:0] o_index_r;

  logic          is_space, is_lf, is_print;
  logic [CW-1:0] chars_inc, glyphs_inc;
  logic [PW:0]   pen_g_sum, pen_s_sum;
  logic [PW-1:0] pen_g, pen_s;
  logic          overflow, wrap, forced, emit, need_div;
  logic [SW-1:0] inner;
  logic [jwwlb_pkg::WRAP_W-1:0] leftover;
  logic [jwwlb_pkg::DIV_NUM_W-1:0] quot;
  logic          div_busy;
  logic [QW:0]   plain_q8, width_sum;
  logic [QW-1:0] wrap_width_q8;
  logic [PW+1:0] carry_diff;
  logic [PW-1:0] carry_pen;
  logic [POSITION_BITS-1:0] e_start;
  logic [CW-1:0] e_len, e_glyphs;
  logic [QW-1:0] e_width;
  logic [jwwlb_pkg::KIND_W-1:0] e_kind;

  assign is_space = (char_r == jwwlb_pkg::CODE_SPACE);
  assign is_lf    = (char_r == jwwlb_pkg::CODE_LF);
  assign is_print = (char_r > jwwlb_pkg::CODE_SPACE);

  assign chars_inc  = (line_chars_r == '1) ? line_chars_r : line_chars_r + 1'b1;
  assign glyphs_inc = (line_glyphs_r == '1) ? line_glyphs_r : line_glyphs_r + 1'b1;

  assign pen_g_sum = {1'b0, pen_r} + (PW+1)'(adv_r);
  assign pen_s_sum = {1'b0, pen_r} + (PW+1)'(space_advance);
  assign pen_g     = pen_g_sum[PW] ? '1 : pen_g_sum[PW-1:0];
  assign pen_s     = pen_s_sum[PW] ? '1 : pen_s_sum[PW-1:0];

  assign overflow = is_print && (pen_g > PW'(wrap_width));
  assign wrap     = overflow && (spc_r != '0);
  assign forced   = overflow && !wrap && (line_glyphs_r != '0);
  assign emit     = is_lf || wrap || forced;

  assign inner    = spc_r - 1'b1;
  assign need_div = wrap && (inner != '0) && (PW'(wrap_width) > pal_r);
  assign leftover = wrap_width - pal_r[jwwlb_pkg::WRAP_W-1:0];

  jwwlb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .numer ({leftover, {jwwlb_pkg::FRAC_W{1'b0}}}),
    .denom (inner),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign plain_q8      = (QW+1)'({space_advance, {jwwlb_pkg::FRAC_W{1'b0}}});
  assign width_sum     = plain_q8 + (need_div ? (QW+1)'(quot) : '0);
  assign wrap_width_q8 = width_sum[QW] ? '1 : width_sum[QW-1:0];

  assign carry_diff = (PW+2)'(pen_g) - (PW+2)'(pal_r) - (PW+2)'(space_advance);
  assign carry_pen  = carry_diff[PW+1] ? '0 : carry_diff[PW-1:0];

  always_comb begin
    e_start  = line_begin_r;
    e_len    = chars_inc;
    e_glyphs = line_glyphs_r;
    e_width  = plain_q8[QW-1:0];
    e_kind   = jwwlb_pkg::KIND_LF;
    if (wrap) begin
      e_len    = cals_r;
      e_glyphs = gals_r;
      e_width  = wrap_width_q8;
      e_kind   = jwwlb_pkg::KIND_WRAP;
    end else if (forced) begin
      e_len    = chars_inc - 1'b1;
      e_kind   = jwwlb_pkg::KIND_FORCED;
    end
  end

  always_comb begin
    char_pos_nxt    = char_pos_r + 1'b1;
    line_begin_nxt  = line_begin_r;
    line_chars_nxt  = chars_inc;
    line_glyphs_nxt = line_glyphs_r;
    pen_nxt         = pen_r;
    spc_nxt         = spc_r;
    pal_nxt         = pal_r;
    cals_nxt        = cals_r;
    gals_nxt        = gals_r;
    if (is_space) begin
      pal_nxt  = pen_r;
      pen_nxt  = pen_s;
      cals_nxt = chars_inc;
      gals_nxt = line_glyphs_r;
      spc_nxt  = (spc_r == '1) ? spc_r : spc_r + 1'b1;
    end else if (is_lf || wrap || forced) begin
      spc_nxt  = '0;
      pal_nxt  = '0;
      cals_nxt = '0;
      gals_nxt = '0;
      if (is_lf) begin
        line_begin_nxt  = char_pos_r + 1'b1;
        line_chars_nxt  = '0;
        line_glyphs_nxt = '0;
        pen_nxt         = '0;
      end else if (wrap) begin
        line_begin_nxt  = line_begin_r + POSITION_BITS'(cals_r);
        line_chars_nxt  = (chars_inc >= cals_r) ? chars_inc - cals_r : '0;
        line_glyphs_nxt = (glyphs_inc >= gals_r) ? glyphs_inc - gals_r : '0;
        pen_nxt         = carry_pen;
      end else begin
        line_begin_nxt  = char_pos_r;
        line_chars_nxt  = CW'(1);
        line_glyphs_nxt = CW'(1);
        pen_nxt         = PW'(adv_r);
      end
    end else if (is_print) begin
      line_glyphs_nxt = glyphs_inc;
      pen_nxt         = pen_g;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char_code;
      adv_r  <= in_glyph_advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_pos_r    <= '0;
      line_begin_r  <= '0;
      line_chars_r  <= '0;
      line_glyphs_r <= '0;
      pen_r         <= '0;
      spc_r         <= '0;
      pal_r         <= '0;
      cals_r        <= '0;
      gals_r        <= '0;
      lines_r       <= '0;
    end else if (cmd.commit) begin
      char_pos_r    <= char_pos_nxt;
      line_begin_r  <= line_begin_nxt;
      line_chars_r  <= line_chars_nxt;
      line_glyphs_r <= line_glyphs_nxt;
      pen_r         <= pen_nxt;
      spc_r         <= spc_nxt;
      pal_r         <= pal_nxt;
      cals_r        <= cals_nxt;
      gals_r        <= gals_nxt;
      if (emit) begin
        lines_r <= lines_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && emit) begin
      o_start_r  <= e_start;
      o_len_r    <= e_len;
      o_glyphs_r <= e_glyphs;
      o_width_r  <= e_width;
      o_kind_r   <= e_kind;
      o_index_r  <= lines_r;
    end
  end

  assign sts.emit     = emit;
  assign sts.need_div = need_div;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_line_start     = o_start_r;
  assign out_line_length    = o_len_r;
  assign out_glyph_count    = o_glyphs_r;
  assign out_space_width_q8 = o_width_r;
  assign out_break_kind     = o_kind_r;
  assign out_line_index     = o_index_r;

endmodule
`default_nettype wire

/* design/jwwlb_ctrl.sv */
`default_nettype none
module jwwlb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire jwwlb_pkg::sts_t  sts,
  output jwwlb_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else if (!sts.emit || sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy && sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule
`default_nettype wire

/* design/justified_word_wrap_line_breaker.sv */
`default_nettype none
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | in_char_code, in_glyph_advance
// out     | output    | out_valid/out_ready| out_line_start .. out_line_index
// cfg     | input     | psel/penable/pready| paddr, pwdata, prdata
//
// Each word is captured, then committed as a state update; the next word waits for it.
// A wrap at a space with two or more spaces and leftover pixels also runs the divider;
// the justified width comes from a 20-step restoring divider.
// A word that closes a line waits while the output register still holds a line.
// rst_n is synchronous; counters clear, registers load 450 and 6.
module justified_word_wrap_line_breaker #(
  parameter int POSITION_BITS = 24,
  parameter int ADVANCE_BITS  = 6
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [jwwlb_pkg::CODE_W-1:0]    in_char_code,
  input  wire logic [ADVANCE_BITS-1:0]         in_glyph_advance,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [POSITION_BITS-1:0]             out_line_start,
  output logic [jwwlb_pkg::CNT_W-1:0]          out_line_length,
  output logic [jwwlb_pkg::CNT_W-1:0]          out_glyph_count,
  output logic [jwwlb_pkg::Q8_W-1:0]           out_space_width_q8,
  output logic [jwwlb_pkg::KIND_W-1:0]         out_break_kind,
  output logic [POSITION_BITS-1:0]             out_line_index,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [jwwlb_pkg::WRAP_W-1:0] wrap_width_r;
  logic [ADVANCE_BITS-1:0]      space_adv_r;
  logic                         cfg_wr;
  jwwlb_pkg::cmd_t              cmd;
  jwwlb_pkg::sts_t              sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_width_r <= jwwlb_pkg::WRAP_WIDTH_RST;
      space_adv_r  <= ADVANCE_BITS'(jwwlb_pkg::SPACE_ADV_RST);
    end else if (cfg_wr) begin
      case (paddr[2])
        jwwlb_pkg::REG_WRAP_WIDTH:    wrap_width_r <= pwdata[jwwlb_pkg::WRAP_W-1:0];
        jwwlb_pkg::REG_SPACE_ADVANCE: space_adv_r  <= pwdata[ADVANCE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      jwwlb_pkg::REG_WRAP_WIDTH:    prdata = 32'(wrap_width_r);
      jwwlb_pkg::REG_SPACE_ADVANCE: prdata = 32'(space_adv_r);
      default:                      prdata = '0;
    endcase
  end

  jwwlb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jwwlb_dp #(
    .POSITION_BITS (POSITION_BITS),
    .ADVANCE_BITS  (ADVANCE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_char_code       (in_char_code),
    .in_glyph_advance   (in_glyph_advance),
    .wrap_width         (wrap_width_r),
    .space_advance      (space_adv_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_start     (out_line_start),
    .out_line_length    (out_line_length),
    .out_glyph_count    (out_glyph_count),
    .out_space_width_q8 (out_space_width_q8),
    .out_break_kind     (out_break_kind),
    .out_line_index     (out_line_index)
  );

  a_word_spans_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted on back-to-back cycles");

  a_line_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=>
      (!out_valid || out_line_index == POSITION_BITS'($past(out_line_index) + 1'b1)))
    else $error("line index did not advance by one");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_break_kind == jwwlb_pkg::KIND_LF ||
                   out_break_kind == jwwlb_pkg::KIND_WRAP ||
                   out_break_kind == jwwlb_pkg::KIND_FORCED))
    else $error("illegal break kind");

endmodule
`default_nettype wire
